/* design/bwalu_pkg.sv */
// Shared types and constants for the byte/word ALU.
`default_nettype none

package bwalu_pkg;

  localparam int DataW = 16;

  typedef enum logic [3:0] {
    OP_INC = 4'd0,
    OP_DEC = 4'd1,
    OP_CLR = 4'd2,
    OP_INV = 4'd3,
    OP_ASR = 4'd4,
    OP_SL  = 4'd5,
    OP_RRC = 4'd6,
    OP_RLC = 4'd7,
    OP_ADD = 4'd8,
    OP_SUB = 4'd9,
    OP_AND = 4'd10,
    OP_OR  = 4'd11,
    OP_XOR = 4'd12,
    OP_XFR = 4'd13
  } op_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             link_we;
    logic             link;
    logic             ovf_we;
    logic             ovf;
  } alu_res_t;

endpackage

`default_nettype wire

/* design/bwalu_exec.sv */
// Combinational datapath of the byte/word ALU: adder, shifter, logic unit.
`default_nettype none

module bwalu_exec (
  input  wire logic [3:0]                  operation,
  input  wire logic                        wide,
  input  wire logic [bwalu_pkg::DataW-1:0] operand_a,
  input  wire logic [bwalu_pkg::DataW-1:0] operand_b,
  input  wire logic                        carry_in,
  output bwalu_pkg::alu_res_t              res
);

  logic [15:0] mask;
  logic [4:0]  wbits;
  logic [15:0] a_m;
  logic [15:0] b_m;
  logic [4:0]  n;
  logic [3:0]  nm1;
  logic [4:0]  sh_l;
  logic        sign;

  logic [15:0] add_x;
  logic [15:0] add_y;
  logic        add_c;
  logic [16:0] sum;
  logic [15:0] add_r;
  logic        add_co;
  logic [15:0] ovf_vec;
  logic        add_v;

  logic [15:0] asr_r;
  logic [15:0] sl_r;
  logic [16:0] rrc_t;
  logic [15:0] rrc_r;
  logic [15:0] cin16;
  logic [15:0] rlc_r;
  logic        lsb_out;
  logic        msb_out;
  logic [15:0] sh_r;
  logic        sh_c;
  logic        sh_top;

  always_comb begin
    mask  = wide ? 16'hFFFF : 16'h00FF;
    wbits = wide ? 5'd16 : 5'd8;
    a_m   = operand_a & mask;
    b_m   = operand_b & mask;
    if (b_m >= {11'd0, wbits}) begin
      n = wbits;
    end else begin
      n = b_m[4:0] + 5'd1;
    end
    nm1  = 4'(n - 5'd1);
    sh_l = wbits - n;
    sign = wide ? a_m[15] : a_m[7];

    add_x = a_m;
    add_y = b_m;
    add_c = 1'b0;
    case (operation)
      bwalu_pkg::OP_DEC: add_y = ~b_m;
      bwalu_pkg::OP_CLR: add_x = 16'h0000;
      bwalu_pkg::OP_INV: add_x = ~a_m;
      bwalu_pkg::OP_SUB: begin
        add_y = ~b_m;
        add_c = 1'b1;
      end
      default: ;
    endcase
    add_x   = add_x & mask;
    add_y   = add_y & mask;
    sum     = {1'b0, add_x} + {1'b0, add_y} + {16'd0, add_c};
    add_r   = sum[15:0] & mask;
    add_co  = wide ? sum[16] : sum[8];
    ovf_vec = (add_x ^ add_r) & (add_y ^ add_r);
    add_v   = wide ? ovf_vec[15] : ovf_vec[7];

    asr_r   = (a_m >> n) | (sign ? ((mask << sh_l[3:0]) & mask) : 16'h0000);
    sl_r    = (a_m << n) & mask;
    rrc_t   = {a_m, carry_in} << sh_l[3:0];
    rrc_r   = ((a_m >> n) | rrc_t[15:0]) & mask;
    cin16   = {15'd0, carry_in} << nm1;
    rlc_r   = ((a_m << n) | cin16 | (a_m >> (sh_l + 5'd1))) & mask;
    lsb_out = a_m[nm1];
    msb_out = a_m[sh_l[3:0]];

    sh_r = asr_r;
    sh_c = lsb_out;
    case (operation)
      bwalu_pkg::OP_SL: begin
        sh_r = sl_r;
        sh_c = msb_out;
      end
      bwalu_pkg::OP_RRC: begin
        sh_r = rrc_r;
        sh_c = lsb_out;
      end
      bwalu_pkg::OP_RLC: begin
        sh_r = rlc_r;
        sh_c = msb_out;
      end
      default: ;
    endcase
    sh_top = wide ? sh_r[15] : sh_r[7];

    res.result  = 16'h0000;
    res.link_we = 1'b0;
    res.link    = 1'b0;
    res.ovf_we  = 1'b0;
    res.ovf     = 1'b0;
    unique case (operation)
      bwalu_pkg::OP_INC, bwalu_pkg::OP_DEC: begin
        res.result = add_r;
        res.ovf_we = 1'b1;
        res.ovf    = add_v;
      end
      bwalu_pkg::OP_CLR, bwalu_pkg::OP_INV, bwalu_pkg::OP_ADD, bwalu_pkg::OP_SUB: begin
        res.result  = add_r;
        res.link_we = 1'b1;
        res.link    = add_co;
        res.ovf_we  = 1'b1;
        res.ovf     = add_v;
      end
      bwalu_pkg::OP_ASR, bwalu_pkg::OP_SL, bwalu_pkg::OP_RRC, bwalu_pkg::OP_RLC: begin
        res.result  = sh_r;
        res.link_we = 1'b1;
        res.link    = sh_c;
        res.ovf_we  = 1'b1;
        res.ovf     = sh_top ^ sh_c;
      end
      bwalu_pkg::OP_AND: res.result = a_m & b_m;
      bwalu_pkg::OP_OR:  res.result = a_m | b_m;
      bwalu_pkg::OP_XOR: res.result = a_m ^ b_m;
      bwalu_pkg::OP_XFR: res.result = a_m;
      default: res.result = 16'h0000;
    endcase
  end

endmodule

`default_nettype wire

/* design/byte_word_alu_with_flags_core.sv */
// Top level of the byte/word ALU with link, overflow, minus and zero flags.
// Each transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle while the output is not stalled; the adder/shifter path sets the cycle.
// A new input is taken while a result waits, as long as the input register is empty.
// Reset clears both valid bits and the link and overflow flags.
`default_nettype none

module byte_word_alu_with_flags_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [3:0]                  operation,
  input  wire logic                        wide,
  input  wire logic [bwalu_pkg::DataW-1:0] operand_a,
  input  wire logic [bwalu_pkg::DataW-1:0] operand_b,
  input  wire logic                        carry_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [bwalu_pkg::DataW-1:0]      result,
  output logic                             link_out,
  output logic                             overflow_out,
  output logic                             minus_out,
  output logic                             zero_out
);

  logic                        s1_valid;
  logic [3:0]                  s1_op;
  logic                        s1_wide;
  logic [bwalu_pkg::DataW-1:0] s1_a;
  logic [bwalu_pkg::DataW-1:0] s1_b;
  logic                        s1_cin;
  logic                        link_flag;
  logic                        overflow_flag;
  logic                        link_next;
  logic                        overflow_next;
  logic                        advance;
  logic                        in_take;
  bwalu_pkg::alu_res_t         res;

  bwalu_exec u_exec (
    .operation (s1_op),
    .wide      (s1_wide),
    .operand_a (s1_a),
    .operand_b (s1_b),
    .carry_in  (s1_cin),
    .res       (res)
  );

  assign advance       = !out_valid || !out_stall;
  assign in_stall      = s1_valid && !advance;
  assign in_take       = in_valid && !in_stall;
  assign link_next     = res.link_we ? res.link : link_flag;
  assign overflow_next = res.ovf_we ? res.ovf : overflow_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      link_flag     <= 1'b0;
      overflow_flag <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          link_flag     <= link_next;
          overflow_flag <= overflow_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op   <= operation;
      s1_wide <= wide;
      s1_a    <= operand_a;
      s1_b    <= operand_b;
      s1_cin  <= carry_in;
    end
    if (advance && s1_valid) begin
      result       <= res.result;
      link_out     <= link_next;
      overflow_out <= overflow_next;
      minus_out    <= s1_wide ? res.result[15] : res.result[7];
      zero_out     <= (res.result == 16'h0000);
    end
  end

  a_flags_track: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (link_out == link_flag) && (overflow_out == overflow_flag))
    else $error("output flags differ from held flags");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (zero_out == (result == 16'h0000)))
    else $error("zero flag does not match result");

  a_logic_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && (s1_op == bwalu_pkg::OP_AND || s1_op == bwalu_pkg::OP_OR ||
      s1_op == bwalu_pkg::OP_XOR || s1_op == bwalu_pkg::OP_XFR))
    |=> (link_flag == $past(link_flag)) && (overflow_flag == $past(overflow_flag)))
    else $error("logical operation changed link or overflow");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a blocked pipeline");

endmodule

`default_nettype wire
